// ===== hdl/usb_bulk_endpoint_finder_assert.svh =====
// Assertion macros shared by the bulk endpoint finder modules.
`ifndef USB_BULK_ENDPOINT_FINDER_ASSERT_SVH
`define USB_BULK_ENDPOINT_FINDER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define UBEF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define UBEF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ubef_pkg.sv =====
// Types and constants of the USB bulk endpoint finder.
package ubef_pkg;

  localparam logic [7:0] TypeEndpoint  = 8'd5;
  localparam logic [7:0] MinEpLength   = 8'd7;
  localparam logic [7:0] XferMask      = 8'h03;
  localparam logic [7:0] XferBulk      = 8'd2;
  localparam logic [7:0] DirInBit      = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  in_endpoint_address;
    logic [7:0]  out_endpoint_address;
    logic [15:0] in_max_packet;
    logic [15:0] out_max_packet;
  } out_beat_t;

endpackage

// ===== hdl/ubef_parse.sv =====
// Descriptor chain parser: per-byte state update and endpoint latching.
module ubef_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_valid_i,
  input  ubef_pkg::in_beat_t beat_i,
  output ubef_pkg::out_beat_t result_o
);

  `include "usb_bulk_endpoint_finder_assert.svh"

  logic [7:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  attr_q, attr_d;
  logic [7:0]  pkt_lo_q, pkt_lo_d;
  logic [7:0]  pkt_hi_q, pkt_hi_d;
  logic        stopped_q, stopped_d;
  logic [7:0]  in_addr_q, in_addr_d;
  logic [7:0]  out_addr_q, out_addr_d;
  logic [15:0] in_pkt_q, in_pkt_d;
  logic [15:0] out_pkt_q, out_pkt_d;

  always_comb begin
    logic stop_now;
    logic ends;
    stop_now   = 1'b0;
    ends       = 1'b0;
    pos_d      = pos_q;
    len_d      = len_q;
    type_d     = type_q;
    addr_d     = addr_q;
    attr_d     = attr_q;
    pkt_lo_d   = pkt_lo_q;
    pkt_hi_d   = pkt_hi_q;
    stopped_d  = stopped_q;
    in_addr_d  = in_addr_q;
    out_addr_d = out_addr_q;
    in_pkt_d   = in_pkt_q;
    out_pkt_d  = out_pkt_q;

    if (beat_valid_i && !stopped_q) begin
      case (pos_q)
        8'd0: begin
          if (beat_i.data_byte == 8'd0) begin
            stop_now  = 1'b1;
            stopped_d = 1'b1;
          end else begin
            len_d  = beat_i.data_byte;
            type_d = 8'd0;
          end
        end
        8'd1: type_d   = beat_i.data_byte;
        8'd2: addr_d   = beat_i.data_byte;
        8'd3: attr_d   = beat_i.data_byte;
        8'd4: pkt_lo_d = beat_i.data_byte;
        8'd5: pkt_hi_d = beat_i.data_byte;
        default: ;
      endcase

      if (!stop_now) begin
        ends = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_d};
        if (ends) begin
          pos_d = 8'd0;
          if (type_d == ubef_pkg::TypeEndpoint && len_d >= ubef_pkg::MinEpLength &&
              (attr_d & ubef_pkg::XferMask) == ubef_pkg::XferBulk) begin
            if ((addr_d & ubef_pkg::DirInBit) != 8'd0) begin
              in_addr_d = addr_d;
              in_pkt_d  = {pkt_hi_d, pkt_lo_d};
            end else begin
              out_addr_d = addr_d;
              out_pkt_d  = {pkt_hi_d, pkt_lo_d};
            end
          end
        end else begin
          pos_d = pos_q + 8'd1;
        end
      end
    end

    result_o.found                = (in_addr_d != 8'd0) && (out_addr_d != 8'd0);
    result_o.in_endpoint_address  = in_addr_d;
    result_o.out_endpoint_address = out_addr_d;
    result_o.in_max_packet        = in_pkt_d;
    result_o.out_max_packet       = out_pkt_d;

    if (beat_valid_i && beat_i.last_byte) begin
      pos_d      = 8'd0;
      len_d      = 8'd0;
      type_d     = 8'd0;
      addr_d     = 8'd0;
      attr_d     = 8'd0;
      pkt_lo_d   = 8'd0;
      pkt_hi_d   = 8'd0;
      stopped_d  = 1'b0;
      in_addr_d  = 8'd0;
      out_addr_d = 8'd0;
      in_pkt_d   = 16'd0;
      out_pkt_d  = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 8'd0;
      len_q      <= 8'd0;
      type_q     <= 8'd0;
      addr_q     <= 8'd0;
      attr_q     <= 8'd0;
      pkt_lo_q   <= 8'd0;
      pkt_hi_q   <= 8'd0;
      stopped_q  <= 1'b0;
      in_addr_q  <= 8'd0;
      out_addr_q <= 8'd0;
      in_pkt_q   <= 16'd0;
      out_pkt_q  <= 16'd0;
    end else begin
      pos_q      <= pos_d;
      len_q      <= len_d;
      type_q     <= type_d;
      addr_q     <= addr_d;
      attr_q     <= attr_d;
      pkt_lo_q   <= pkt_lo_d;
      pkt_hi_q   <= pkt_hi_d;
      stopped_q  <= stopped_d;
      in_addr_q  <= in_addr_d;
      out_addr_q <= out_addr_d;
      in_pkt_q   <= in_pkt_d;
      out_pkt_q  <= out_pkt_d;
    end
  end

  `UBEF_ASSERT_NXT(a_last_clears, beat_valid_i && beat_i.last_byte,
                   pos_q == 8'd0 && !stopped_q && in_addr_q == 8'd0 && out_addr_q == 8'd0,
                   "Parser state not cleared after the last beat.")
  `UBEF_ASSERT_IMP(a_stop_at_start, stopped_q, pos_q == 8'd0,
                   "Parsing stopped inside a descriptor.")
  `UBEF_ASSERT_IMP(a_dir_bits, 1'b1, (in_addr_q == 8'd0 || in_addr_q[7]) && !out_addr_q[7],
                   "Latched endpoint has the wrong direction bit.")

endmodule

// ===== hdl/usb_bulk_endpoint_finder.sv =====
// Top level of the USB bulk endpoint finder: input register, parser and result register.
// The block takes one descriptor byte per cycle, with no bubbles, as long as the result side
// does not stall. Each beat is captured in an input register and parsed from there; when
// the beat marked last is parsed, its result beat is written to the output register, so a
// result is offered only after its last byte has passed the input and the output register.
// Once in the input register, a beat that is not marked last never waits for the result side;
// a last beat waits there only while an earlier result is still held and stalled, and the
// input stalls behind it.
module usb_bulk_endpoint_finder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ubef_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ubef_pkg::out_beat_t out_beat_o
);

  `include "usb_bulk_endpoint_finder_assert.svh"

  logic                s1_valid_q;
  ubef_pkg::in_beat_t  s1_beat_q;
  logic                advance;
  logic                out_valid_q;
  ubef_pkg::out_beat_t out_beat_q;
  ubef_pkg::out_beat_t result;

  assign advance    = s1_valid_q && (!s1_beat_q.last_byte || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_beat_q <= in_beat_i;
    end
  end

  ubef_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (advance),
    .beat_i       (s1_beat_q),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_beat_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_beat_q.last_byte) begin
      out_beat_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  `UBEF_ASSERT_IMP(a_stall_needs_beat, in_stall_o, s1_valid_q,
                   "Input stalled with an empty input register.")
  `UBEF_ASSERT_IMP(a_result_from_last, $rose(out_valid_o),
                   $past(s1_valid_q && s1_beat_q.last_byte),
                   "Result beat without a last byte.")
  `UBEF_ASSERT_IMP(a_found_flag, out_valid_o,
                   out_beat_o.found == (out_beat_o.in_endpoint_address != 8'd0 &&
                                        out_beat_o.out_endpoint_address != 8'd0),
                   "Found flag disagrees with the addresses.")

endmodule

// ===== sim/ubef_checker.sv =====
// Checker for the bulk endpoint finder: predicts each result from the accepted bytes and compares.
module ubef_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ubef_pkg::in_beat_t  in_beat_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ubef_pkg::out_beat_t out_beat_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  desc_pos;
  logic [7:0]  desc_len;
  logic [7:0]  desc_type;
  logic [7:0]  cand_addr;
  logic [7:0]  cand_attr;
  logic [7:0]  cand_pkt_lo;
  logic [7:0]  cand_pkt_hi;
  logic        walk_stopped;
  logic [7:0]  bulk_in_addr;
  logic [7:0]  bulk_out_addr;
  logic [15:0] bulk_in_pkt;
  logic [15:0] bulk_out_pkt;

  ubef_pkg::out_beat_t endpoint_reports_q[$];

  task automatic clear_tree_state();
    desc_pos      = '0;
    desc_len      = '0;
    desc_type     = '0;
    cand_addr     = '0;
    cand_attr     = '0;
    cand_pkt_lo   = '0;
    cand_pkt_hi   = '0;
    walk_stopped  = 1'b0;
    bulk_in_addr  = '0;
    bulk_out_addr = '0;
    bulk_in_pkt   = '0;
    bulk_out_pkt  = '0;
  endtask

  task automatic close_descriptor();
    if (desc_type == ubef_pkg::TypeEndpoint && desc_len >= ubef_pkg::MinEpLength &&
        (cand_attr & ubef_pkg::XferMask) == ubef_pkg::XferBulk) begin
      if ((cand_addr & ubef_pkg::DirInBit) != 8'h00) begin
        bulk_in_addr = cand_addr;
        bulk_in_pkt  = {cand_pkt_hi, cand_pkt_lo};
      end else begin
        bulk_out_addr = cand_addr;
        bulk_out_pkt  = {cand_pkt_hi, cand_pkt_lo};
      end
    end
  endtask

  task automatic walk_descriptor_byte(input logic [7:0] b);
    logic [7:0] p;
    p = desc_pos;
    if (walk_stopped) return;
    case (p)
      8'd0: begin
        if (b == 8'h00) begin
          walk_stopped = 1'b1;
          return;
        end
        desc_len  = b;
        desc_type = '0;
      end
      8'd1: desc_type = b;
      8'd2: cand_addr = b;
      8'd3: cand_attr = b;
      8'd4: cand_pkt_lo = b;
      8'd5: cand_pkt_hi = b;
      default: ;
    endcase
    if (int'(p) + 1 >= int'(desc_len)) begin
      close_descriptor();
      desc_pos = '0;
    end else begin
      desc_pos = p + 8'd1;
    end
  endtask

  task automatic accept_byte(input ubef_pkg::in_beat_t beat);
    ubef_pkg::out_beat_t want;
    walk_descriptor_byte(beat.data_byte);
    if (beat.last_byte) begin
      want.found                = (bulk_in_addr != 8'h00) && (bulk_out_addr != 8'h00);
      want.in_endpoint_address  = bulk_in_addr;
      want.out_endpoint_address = bulk_out_addr;
      want.in_max_packet        = bulk_in_pkt;
      want.out_max_packet       = bulk_out_pkt;
      endpoint_reports_q.push_back(want);
      clear_tree_state();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic check_report(input ubef_pkg::out_beat_t got);
    ubef_pkg::out_beat_t want;
    if (endpoint_reports_q.size() == 0) begin
      report_mismatch("result beat with none pending", 64'(got), 64'd0);
      return;
    end
    want = endpoint_reports_q.pop_front();
    if (got.found !== want.found)
      report_mismatch("found", 64'(got.found), 64'(want.found));
    if (got.in_endpoint_address !== want.in_endpoint_address)
      report_mismatch("in_endpoint_address", 64'(got.in_endpoint_address),
                      64'(want.in_endpoint_address));
    if (got.out_endpoint_address !== want.out_endpoint_address)
      report_mismatch("out_endpoint_address", 64'(got.out_endpoint_address),
                      64'(want.out_endpoint_address));
    if (got.in_max_packet !== want.in_max_packet)
      report_mismatch("in_max_packet", 64'(got.in_max_packet), 64'(want.in_max_packet));
    if (got.out_max_packet !== want.out_max_packet)
      report_mismatch("out_max_packet", 64'(got.out_max_packet), 64'(want.out_max_packet));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_tree_state();
      endpoint_reports_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_report(out_beat_i);
      if (in_valid_i && !in_stall_i) accept_byte(in_beat_i);
      pending_o <= endpoint_reports_q.size();
    end
  end

endmodule

// ===== sim/tb_usb_bulk_endpoint_finder.sv =====
// Testbench top for the bulk endpoint finder: clock, reset, descriptor tree stimulus and verdict.
module tb_usb_bulk_endpoint_finder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CfgDescType = 8'h02;
  localparam int HoldCycles = 400;
  localparam int IdleLimit  = 3000;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  ubef_pkg::in_beat_t  in_beat     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  ubef_pkg::out_beat_t out_beat;
  logic                hold_toggle = 1'b0;
  logic                hold_seen   = 1'b0;
  int                  fail_count;
  int                  pending;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  beats_sent    = 0;
  int                  quiet_cycles  = 0;
  logic [7:0]          tree_q[$];

  always #4 clk = ~clk;

  usb_bulk_endpoint_finder i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  ubef_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_beat_i   (out_beat),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_tree();
    for (int i = 0; i < tree_q.size(); i++) send_beat(tree_q[i], i == tree_q.size() - 1);
    tree_q.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic push_descriptor(input int len, input logic [7:0] dtype);
    tree_q.push_back(8'(len));
    if (len >= 2) tree_q.push_back(dtype);
    for (int i = 2; i < len; i++) tree_q.push_back(8'($urandom));
  endtask

  task automatic push_endpoint(input int len, input logic [7:0] addr, input logic [7:0] attr,
                               input logic [15:0] pkt);
    tree_q.push_back(8'(len));
    tree_q.push_back(ubef_pkg::TypeEndpoint);
    tree_q.push_back(addr);
    tree_q.push_back(attr);
    tree_q.push_back(pkt[7:0]);
    tree_q.push_back(pkt[15:8]);
    for (int i = 6; i < len; i++) tree_q.push_back(8'($urandom));
  endtask

  task automatic build_random_tree();
    int kind;
    int len;
    int cut;
    logic [7:0] addr;
    logic [7:0] attr;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 24)) tree_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        kind = $urandom_range(9);
        if (kind < 6) begin
          len  = ($urandom_range(3) == 0) ? $urandom_range(8, 12) : 7;
          addr = 8'($urandom);
          if ($urandom_range(15) == 0) addr = addr & ubef_pkg::DirInBit;
          attr = 8'($urandom);
          if ($urandom_range(3) != 0) begin
            attr = (attr & ~ubef_pkg::XferMask) | ubef_pkg::XferBulk;
          end
          push_endpoint(len, addr, attr, 16'($urandom));
        end else if (kind < 8) begin
          push_descriptor($urandom_range(1, 12),
                          ($urandom_range(1) == 1) ? ubef_pkg::TypeEndpoint : 8'($urandom));
        end else if (kind == 8) begin
          push_descriptor(9, CfgDescType);
        end else begin
          push_descriptor($urandom_range(0, 12), 8'($urandom));
        end
      end
      case ($urandom_range(9))
        0: begin
          tree_q.push_back(8'h00);
          repeat ($urandom_range(0, 8)) tree_q.push_back(8'($urandom));
        end
        1: begin
          cut = $urandom_range(1, 5);
          while (cut > 0 && tree_q.size() > 1) begin
            void'(tree_q.pop_back());
            cut--;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic run_random_trees(input int beat_target);
    while (beats_sent < beat_target) begin
      build_random_tree();
      send_tree();
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("usb_bulk_endpoint_finder verification failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 28;
    recv_idle_pct <= 71;

    // A length-one descriptor, a bulk IN with the largest packet size, and a bulk OUT
    // whose descriptor closes on the last byte.
    push_descriptor(1, 8'h00);
    push_endpoint(7, 8'h81, ubef_pkg::XferBulk, 16'hFFFF);
    push_endpoint(7, 8'h01, 8'hFE, 16'h0000);
    send_tree();
    // A zero length byte stops the walk; the byte after it is ignored.
    tree_q.push_back(8'h00);
    tree_q.push_back(8'hFF);
    send_tree();
    // An endpoint cut short by the end of the tree is not used.
    push_endpoint(7, 8'h82, ubef_pkg::XferBulk, 16'h0040);
    void'(tree_q.pop_back());
    send_tree();
    // The last byte is itself a zero length byte.
    tree_q.push_back(8'h00);
    send_tree();

    run_random_trees(520);
    wait_drained();

    // The result side holds off while short trees keep coming, so the block backs up.
    send_idle_pct = 0;
    hold_toggle <= ~hold_toggle;
    repeat (40) begin
      repeat ($urandom_range(1, 3)) tree_q.push_back(8'($urandom));
      send_tree();
    end
    wait_drained();

    send_idle_pct = 71;
    recv_idle_pct <= 28;
    run_random_trees(1040);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random_trees(1560);
    wait_drained();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("usb_bulk_endpoint_finder verification clean");
    end else begin
      $display("usb_bulk_endpoint_finder verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ubef_pkg.sv
hdl/ubef_parse.sv
hdl/usb_bulk_endpoint_finder.sv
sim/ubef_checker.sv
sim/tb_usb_bulk_endpoint_finder.sv
